@@ hdl/name_hash_sorted_table_lookup_defines.svh @@
// assertion macros shared by the table lookup block
`ifndef NAME_HASH_SORTED_TABLE_LOOKUP_DEFINES_SVH
`define NAME_HASH_SORTED_TABLE_LOOKUP_DEFINES_SVH

`ifndef SYNTH
`define NHSTL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nhstl same-cycle check failed");
`define NHSTL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nhstl next-cycle check failed");
`else
`define NHSTL_ASSERT_SAME(lbl, ante, cons)
`define NHSTL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/nhstl_pkg.sv @@
package nhstl_pkg;

	localparam int unsigned ENTRY_W = 128;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	// multiplier is 2^40 + 0x1b3, so only the low part needs a real product
	localparam logic [63:0] FNV_MULT_LO = 64'h0000_0000_0000_01B3;
	localparam int unsigned FNV_MULT_SHIFT = 40;

	localparam logic [31:0] LEN_MIN = 32'd16;
	localparam logic [31:0] LEN_MAX = 32'd1048576;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_ORDER     = 3'd1;
	localparam logic [2:0] STAT_OFFSET    = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [2:0] STAT_BAD_LEN   = 3'd5;
	localparam logic [2:0] STAT_EMPTY     = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic step;
		logic last;
	} fnv_ctl_t;

endpackage

@@ hdl/nhstl_ram.sv @@
module nhstl_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/nhstl_fnv.sv @@
module nhstl_fnv (
	input  logic                clk,
	input  logic                arst_n,
	input  nhstl_pkg::fnv_ctl_t ctl,
	input  logic [7:0]          name_byte,
	output logic [63:0]         digest_next
);

	logic [63:0] digest_q;
	logic [7:0]  folded;
	logic [63:0] mixed;

	// fold ascii upper case to lower case
	always_comb begin
		folded = name_byte;
		if (name_byte >= 8'h41 && name_byte <= 8'h5A) begin
			folded = name_byte + 8'h20;
		end
	end

	assign mixed = digest_q ^ {56'd0, folded};
	assign digest_next = (mixed << nhstl_pkg::FNV_MULT_SHIFT)
		+ (mixed * nhstl_pkg::FNV_MULT_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_q <= nhstl_pkg::FNV_BASIS;
		end else if (ctl.step) begin
			digest_q <= ctl.last ? nhstl_pkg::FNV_BASIS : digest_next;
		end
	end

endmodule

@@ hdl/name_hash_sorted_table_lookup.sv @@
// Sorted hash table with name lookup. Commands are taken when start is high and busy is
// low. A load, a clear or a name byte that is not the last leaves busy low; a load
// answers on done in the following cycle. A last name byte on an empty table answers the
// same way. Otherwise it starts a binary search over the entry RAM, which has separate
// write and read ports: each probe is an address step, then a compare of the registered
// read data, at most floor(log2(count))+1 probes are made, and a miss is reported from
// a final address step once the range is empty. Busy stays high while the search runs.
// Every result is shown on done for one cycle and cannot be stalled by the receiver.
// cfg_ready is always high; write payload_start only while idle.
`include "name_hash_sorted_table_lookup_defines.svh"

module name_hash_sorted_table_lookup #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] entry_hash,
	input  logic [31:0] entry_offset,
	input  logic [31:0] entry_length,
	input  logic [7:0]  name_byte,
	input  logic        name_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [9:0]  found_index,
	output logic [31:0] found_offset,
	output logic [20:0] found_length
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	nhstl_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q, hi_q;
	logic [63:0]      last_hash_q;
	logic [63:0]      key_q;
	logic [31:0]      payload_start_q;

	logic        done_q;
	logic [2:0]  status_q;
	logic [9:0]  index_q;
	logic [31:0] offset_q;
	logic [20:0] length_q;

	logic accept, is_load, is_byte, is_clear, lookup_go;
	logic load_full, load_order, load_low, load_ok, load_flush;

	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid, mid_inc;
	logic             range_open;

	logic [nhstl_pkg::ENTRY_W-1:0] rdata;
	logic [63:0] rd_hash;
	logic [31:0] rd_off, rd_len;
	logic        hit;

	logic [63:0] digest_next;
	nhstl_pkg::fnv_ctl_t fnv_ctl;

	logic              res_valid;
	logic [2:0]        res_status;
	logic [CNT_W-1:0]  res_index_src;
	logic [CNT_W+9:0]  res_index_ext;
	logic [31:0]       res_offset;
	logic [20:0]       res_length;

	assign accept    = start && !busy;
	assign is_load   = accept && (cmd == nhstl_pkg::CMD_LOAD);
	assign is_byte   = accept && (cmd == nhstl_pkg::CMD_BYTE);
	assign is_clear  = accept && (cmd == nhstl_pkg::CMD_CLEAR);
	assign lookup_go = is_byte && name_last && (count_q != '0);

	assign load_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign load_order = (count_q != '0) && (entry_hash <= last_hash_q);
	assign load_low   = (entry_offset < payload_start_q);
	assign load_ok    = is_load && !load_full && !load_order && !load_low;
	assign load_flush = is_load && !load_full && (load_order || load_low);

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CNT_W:1];
	assign mid_inc    = mid + CNT_W'(1);
	assign range_open = (lo_q < hi_q);

	assign rd_hash = rdata[127:64];
	assign rd_off  = rdata[63:32];
	assign rd_len  = rdata[31:0];
	assign hit     = (rd_hash == key_q);

	assign fnv_ctl.step = is_byte;
	assign fnv_ctl.last = name_last;

	nhstl_fnv u_fnv (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (fnv_ctl),
		.name_byte   (name_byte),
		.digest_next (digest_next)
	);

	nhstl_ram #(
		.WIDTH (nhstl_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({entry_hash, entry_offset, entry_length}),
		.raddr (mid[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nhstl_pkg::ST_IDLE: begin
				if (lookup_go) begin
					state_d = nhstl_pkg::ST_READ;
				end
			end
			nhstl_pkg::ST_READ: begin
				state_d = range_open ? nhstl_pkg::ST_CMP : nhstl_pkg::ST_IDLE;
			end
			nhstl_pkg::ST_CMP: begin
				state_d = hit ? nhstl_pkg::ST_IDLE : nhstl_pkg::ST_READ;
			end
		endcase
	end

	always_comb begin
		res_valid     = 1'b0;
		res_status    = nhstl_pkg::STAT_OK;
		res_index_src = '0;
		res_offset    = '0;
		res_length    = '0;
		unique case (state_q)
			nhstl_pkg::ST_IDLE: begin
				if (is_load) begin
					res_valid = 1'b1;
					priority if (load_full) begin
						res_status = nhstl_pkg::STAT_FULL;
					end else if (load_order) begin
						res_status = nhstl_pkg::STAT_ORDER;
					end else if (load_low) begin
						res_status = nhstl_pkg::STAT_OFFSET;
					end else begin
						res_status    = nhstl_pkg::STAT_OK;
						res_index_src = count_q;
					end
				end else if (is_byte && name_last && (count_q == '0)) begin
					res_valid  = 1'b1;
					res_status = nhstl_pkg::STAT_EMPTY;
				end
			end
			nhstl_pkg::ST_READ: begin
				if (!range_open) begin
					res_valid  = 1'b1;
					res_status = nhstl_pkg::STAT_NOT_FOUND;
				end
			end
			nhstl_pkg::ST_CMP: begin
				if (hit) begin
					res_valid     = 1'b1;
					res_index_src = mid;
					res_offset    = rd_off;
					if (rd_len < nhstl_pkg::LEN_MIN || rd_len > nhstl_pkg::LEN_MAX) begin
						res_status = nhstl_pkg::STAT_BAD_LEN;
					end else begin
						res_status = nhstl_pkg::STAT_OK;
						res_length = rd_len[20:0];
					end
				end
			end
		endcase
	end

	// index reported modulo 1024
	assign res_index_ext = {10'd0, res_index_src};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= nhstl_pkg::ST_IDLE;
			count_q         <= '0;
			payload_start_q <= '0;
			done_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (cfg_valid && cfg_ready) begin
				payload_start_q <= cfg_data;
			end
			if (is_clear || load_flush) begin
				count_q <= '0;
			end else if (load_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			last_hash_q <= entry_hash;
		end
		if (lookup_go) begin
			key_q <= digest_next;
			lo_q  <= '0;
			hi_q  <= count_q;
		end else if (state_q == nhstl_pkg::ST_CMP && !hit) begin
			if (rd_hash < key_q) begin
				lo_q <= mid_inc;
			end else begin
				hi_q <= mid;
			end
		end
		if (res_valid) begin
			status_q <= res_status;
			index_q  <= res_index_ext[9:0];
			offset_q <= res_offset;
			length_q <= res_length;
		end
	end

	assign busy         = (state_q != nhstl_pkg::ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign found_index  = index_q;
	assign found_offset = offset_q;
	assign found_length = length_q;

	`NHSTL_ASSERT_SAME(a_search_ends_with_result, $fell(busy), done)
	`NHSTL_ASSERT_SAME(a_no_result_while_searching, done, !busy)
	`NHSTL_ASSERT_NEXT(a_load_answers, start && !busy && (cmd == nhstl_pkg::CMD_LOAD), done)
	`NHSTL_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`NHSTL_ASSERT_SAME(a_cmp_range_open, state_q == nhstl_pkg::ST_CMP, lo_q < hi_q)

endmodule

@@ tb/tb_name_hash_sorted_table_lookup.sv @@
`timescale 1ns / 1ps

module tb_name_hash_sorted_table_lookup;

	localparam int unsigned DEPTH     = 1024;
	localparam int unsigned NAME_MAX  = 8;
	localparam int unsigned POOL      = 20;
	localparam int unsigned SETTLE    = 26;
	localparam int unsigned LIMIT     = 600000;
	localparam int unsigned ITEM_GOAL = 1250;
	localparam logic [1:0]  CMD_SPARE = 2'd3;
	localparam logic [63:0] FNV_MULT  = 64'h0000_0100_0000_01B3;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  index;
		logic [31:0] offset;
		logic [20:0] length;
	} lookup_result_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] offset;
		logic [31:0] length;
	} entry_t;

	// mirrors the table, the running name digest and payload_start
	class lookup_book;
		logic [63:0] key_tab [DEPTH];
		logic [31:0] off_tab [DEPTH];
		logic [31:0] len_tab [DEPTH];
		int unsigned fill;
		logic [63:0] digest;
		logic [31:0] pay_start;
		lookup_result_t owed[$];
		int unsigned checked;
		int unsigned errors;
		int unsigned stat_tally [8];

		function new();
			fill = 0;
			digest = nhstl_pkg::FNV_BASIS;
			pay_start = '0;
			checked = 0;
			errors = 0;
			foreach (stat_tally[i]) stat_tally[i] = 0;
		endfunction

		static function logic [63:0] fnv_fold(logic [63:0] h, logic [7:0] b);
			logic [7:0] c;
			c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
			return (h ^ {56'd0, c}) * FNV_MULT;
		endfunction

		function void note_command(logic [1:0] c, logic [63:0] h, logic [31:0] o,
				logic [31:0] l, logic [7:0] b, logic lst);
			lookup_result_t r;
			logic [63:0] d;
			int hit;
			r = '0;
			unique case (c)
				nhstl_pkg::CMD_LOAD: begin
					if (fill >= DEPTH) begin
						r.status = nhstl_pkg::STAT_FULL;
					end else if (fill > 0 && h <= key_tab[fill - 1]) begin
						r.status = nhstl_pkg::STAT_ORDER;
						fill = 0;
					end else if (o < pay_start) begin
						r.status = nhstl_pkg::STAT_OFFSET;
						fill = 0;
					end else begin
						key_tab[fill] = h;
						off_tab[fill] = o;
						len_tab[fill] = l;
						r.status = nhstl_pkg::STAT_OK;
						r.index = fill[9:0];
						fill++;
					end
					owed.push_back(r);
				end
				nhstl_pkg::CMD_BYTE: begin
					digest = fnv_fold(digest, b);
					if (lst) begin
						d = digest;
						digest = nhstl_pkg::FNV_BASIS;
						if (fill == 0) begin
							r.status = nhstl_pkg::STAT_EMPTY;
						end else begin
							hit = -1;
							for (int i = 0; i < fill; i++)
								if (key_tab[i] == d) hit = i;
							if (hit < 0) begin
								r.status = nhstl_pkg::STAT_NOT_FOUND;
							end else begin
								r.index = hit[9:0];
								r.offset = off_tab[hit];
								if (len_tab[hit] < nhstl_pkg::LEN_MIN ||
										len_tab[hit] > nhstl_pkg::LEN_MAX) begin
									r.status = nhstl_pkg::STAT_BAD_LEN;
								end else begin
									r.status = nhstl_pkg::STAT_OK;
									r.length = len_tab[hit][20:0];
								end
							end
						end
						owed.push_back(r);
					end
				end
				nhstl_pkg::CMD_CLEAR: fill = 0;
				default: ;
			endcase
		endfunction

		function void flag(string field, logic [63:0] e, logic [63:0] a);
			errors++;
			if (errors <= 40)
				$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, e, a);
		endfunction

		function void check_result(lookup_result_t got);
			lookup_result_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t ns: unexpected result, expected none actual status %0d index %0d",
						$time, got.status, got.index);
				return;
			end
			e = owed.pop_front();
			checked++;
			stat_tally[e.status]++;
			if (got.status !== e.status) flag("status", 64'(e.status), 64'(got.status));
			if (got.index !== e.index) flag("found_index", 64'(e.index), 64'(got.index));
			if (got.offset !== e.offset) flag("found_offset", 64'(e.offset), 64'(got.offset));
			if (got.length !== e.length) flag("found_length", 64'(e.length), 64'(got.length));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = '0;
	logic [63:0] entry_hash = '0;
	logic [31:0] entry_offset = '0;
	logic [31:0] entry_length = '0;
	logic [7:0]  name_byte = '0;
	logic        name_last = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [2:0]  status;
	logic [9:0]  found_index;
	logic [31:0] found_offset;
	logic [20:0] found_length;

	lookup_book book;
	lookup_result_t seen_result;
	entry_t staged[$];
	logic [7:0]  pool_bytes [POOL][NAME_MAX];
	int unsigned pool_len [POOL];
	logic [63:0] pool_hash [POOL];
	int unsigned items = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;
	bit no_gaps = 1'b0;

	name_hash_sorted_table_lookup #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.entry_hash(entry_hash),
		.entry_offset(entry_offset),
		.entry_length(entry_length),
		.name_byte(name_byte),
		.name_last(name_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.found_index(found_index),
		.found_offset(found_offset),
		.found_length(found_length)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles", LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_result.status = status;
			seen_result.index = found_index;
			seen_result.offset = found_offset;
			seen_result.length = found_length;
			book.check_result(seen_result);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] name_hash(int i);
		logic [63:0] h;
		h = nhstl_pkg::FNV_BASIS;
		for (int j = 0; j < pool_len[i]; j++)
			h = lookup_book::fnv_fold(h, pool_bytes[i][j]);
		return h;
	endfunction

	function automatic logic [31:0] pick_offset();
		return $urandom_range(32'hFFFF_FFFF, book.pay_start);
	endfunction

	function automatic logic [31:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return $urandom_range(nhstl_pkg::LEN_MAX, nhstl_pkg::LEN_MIN);
		if (r < 65) return $urandom_range(1) ? nhstl_pkg::LEN_MIN : nhstl_pkg::LEN_MAX;
		if (r < 80) return $urandom_range(15);
		return $urandom_range(32'hFFFF_FFFF, nhstl_pkg::LEN_MAX + 1);
	endfunction

	// one transaction on the command side, with random idle cycles ahead of it unless no_gaps is set
	task automatic issue(logic [1:0] c, logic [63:0] h, logic [31:0] o, logic [31:0] l,
			logic [7:0] b, logic lst);
		if (!no_gaps) begin
			while ($urandom_range(99) < 26) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd <= c;
		entry_hash <= h;
		entry_offset <= o;
		entry_length <= l;
		name_byte <= b;
		name_last <= lst;
		do @(posedge clk); while (busy);
		book.note_command(c, h, o, l, b, lst);
		items++;
	endtask

	task automatic issue_noise(logic [1:0] c);
		issue(c, rand64(), $urandom, $urandom, 8'($urandom), 1'($urandom));
	endtask

	// drains all results, lets the block settle, then writes payload_start
	task automatic set_payload_start(logic [31:0] v);
		start <= 1'b0;
		while (book.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		book.pay_start = v;
		settings_used++;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_name(int i, string s);
		pool_len[i] = s.len();
		for (int j = 0; j < s.len(); j++) pool_bytes[i][j] = s[j];
		pool_hash[i] = name_hash(i);
	endtask

	task automatic make_name(int i);
		int unsigned r;
		pool_len[i] = $urandom_range(NAME_MAX, 1);
		for (int j = 0; j < pool_len[i]; j++) begin
			r = $urandom_range(9);
			if (r < 3) pool_bytes[i][j] = 8'h41 + 8'($urandom_range(25));
			else if (r < 6) pool_bytes[i][j] = 8'h61 + 8'($urandom_range(25));
			else pool_bytes[i][j] = 8'($urandom_range(255));
		end
		pool_hash[i] = name_hash(i);
	endtask

	// with scramble set, letters may flip case, the digest must not change
	task automatic send_name(int i, bit scramble);
		logic [7:0] b;
		for (int j = 0; j < pool_len[i]; j++) begin
			b = pool_bytes[i][j];
			if (scramble && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(1))
				b = b ^ 8'h20;
			if ($urandom_range(99) < 8) issue_noise(CMD_SPARE);
			issue(nhstl_pkg::CMD_BYTE, rand64(), $urandom, $urandom, b, j == pool_len[i] - 1);
		end
	endtask

	// sorts the staged entries and loads them, optionally with one bad load at break_at
	task automatic load_staged(int break_at);
		entry_t tmp;
		int j;
		logic [63:0] prev;
		bit have_prev;
		logic [63:0] bad_key;
		logic [31:0] bad_off;
		for (int i = 1; i < staged.size(); i++) begin
			tmp = staged[i];
			j = i;
			while (j > 0 && staged[j - 1].key > tmp.key) begin
				staged[j] = staged[j - 1];
				j--;
			end
			staged[j] = tmp;
		end
		have_prev = 1'b0;
		prev = '0;
		for (int i = 0; i < staged.size(); i++) begin
			if (i == break_at) begin
				bad_key = (i > 0) ? staged[i - 1].key - $urandom_range(2) : staged[0].key;
				bad_off = staged[i].offset;
				if (i > 0 && book.pay_start != 0 && $urandom_range(1)) begin
					bad_key = staged[i].key;
					bad_off = $urandom_range(book.pay_start - 1, 0);
				end
				issue(nhstl_pkg::CMD_LOAD, bad_key, bad_off, pick_length(),
					8'($urandom), 1'($urandom));
			end
			if (have_prev && staged[i].key == prev) continue;
			prev = staged[i].key;
			have_prev = 1'b1;
			issue(nhstl_pkg::CMD_LOAD, staged[i].key, staged[i].offset, staged[i].length,
				8'($urandom), 1'($urandom));
		end
		staged.delete();
	endtask

	task automatic run_phase(int n_names, int n_entries, int n_lookups, logic [31:0] ps,
			bit allow_break);
		int unsigned r;
		set_payload_start(ps);
		issue_noise(nhstl_pkg::CMD_CLEAR);
		for (int i = 0; i < n_names; i++) begin
			make_name(i);
			staged.push_back(entry_t'{pool_hash[i], pick_offset(), pick_length()});
		end
		for (int i = n_names; i < n_entries; i++)
			staged.push_back(entry_t'{rand64(), pick_offset(), pick_length()});
		load_staged((allow_break && $urandom_range(99) < 40) ?
			int'($urandom_range(n_entries - 1)) : -1);
		if (n_entries >= DEPTH)
			issue(nhstl_pkg::CMD_LOAD, rand64(), pick_offset(), pick_length(),
				8'($urandom), 1'($urandom));
		for (int k = 0; k < n_lookups; k++) begin
			r = $urandom_range(99);
			if (r < 70) begin
				send_name($urandom_range(n_names - 1), 1'b1);
			end else if (r < 88) begin
				make_name(POOL - 1);
				send_name(POOL - 1, 1'b0);
			end else if (r < 94) begin
				issue_noise(CMD_SPARE);
			end else if (r < 97) begin
				issue(nhstl_pkg::CMD_BYTE, rand64(), $urandom, $urandom, 8'($urandom), 1'b1);
			end else if (r < 99) begin
				issue(nhstl_pkg::CMD_LOAD, rand64(), pick_offset(), pick_length(),
					8'($urandom), 1'($urandom));
			end else begin
				issue_noise(nhstl_pkg::CMD_CLEAR);
			end
		end
	endtask

	initial begin
		int ph;
		logic [31:0] ps;
		int w;
		book = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookup on an empty table, zero byte
		issue(nhstl_pkg::CMD_BYTE, '0, '0, '0, 8'h00, 1'b1);
		set_name(0, "AB");
		set_name(1, "Z");
		set_name(2, "q?");
		pool_bytes[2][1] = 8'h00;
		pool_hash[2] = name_hash(2);
		set_name(3, "MiD");
		set_name(4, "@[?");
		pool_bytes[4][2] = 8'hFF;
		staged.push_back(entry_t'{64'd0, 32'd0, 32'd0});
		staged.push_back(entry_t'{pool_hash[0], $urandom, nhstl_pkg::LEN_MIN});
		staged.push_back(entry_t'{pool_hash[1], $urandom, nhstl_pkg::LEN_MAX});
		staged.push_back(entry_t'{pool_hash[2], $urandom, nhstl_pkg::LEN_MIN - 1});
		staged.push_back(entry_t'{pool_hash[3], $urandom, nhstl_pkg::LEN_MAX + 1});
		staged.push_back(entry_t'{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		load_staged(-1);
		send_name(0, 1'b0);
		send_name(1, 1'b0);
		send_name(2, 1'b0);
		send_name(3, 1'b1);
		send_name(4, 1'b0);
		// equal hash breaks the order and empties the table
		issue(nhstl_pkg::CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, '1, 32'd64, 8'hFF, 1'b1);
		set_payload_start(32'h0000_0100);
		issue(nhstl_pkg::CMD_LOAD, 64'h10, 32'h0000_00FF, 32'd64, '0, 1'b0);
		issue(nhstl_pkg::CMD_LOAD, 64'h20, 32'h0000_0100, 32'd64, '0, 1'b0);
		issue(nhstl_pkg::CMD_LOAD, 64'h1F, 32'h0000_0200, 32'd64, '0, 1'b0);
		issue(nhstl_pkg::CMD_LOAD, 64'h30, 32'h0000_0200, 32'd64, '0, 1'b0);
		issue_noise(CMD_SPARE);
		issue_noise(nhstl_pkg::CMD_CLEAR);
		issue(nhstl_pkg::CMD_BYTE, rand64(), $urandom, $urandom, 8'h41, 1'b1);

		ph = 0;
		while (items < ITEM_GOAL || ph < 3) begin
			case (ph % 5)
				0: ps = $urandom_range(32'h0010_0000, 0);
				1: ps = $urandom;
				2: ps = 32'hFFFF_FFFF;
				default: ps = '0;
			endcase
			no_gaps = (ph == 1);
			if (ph == 2)
				run_phase(8, DEPTH, 10, $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF, 1'b0);
			else
				run_phase($urandom_range(12, 1), $urandom_range(12, 1) + 8,
					$urandom_range(25, 10), ps, 1'b1);
			ph++;
		end
		no_gaps = 1'b0;

		start <= 1'b0;
		for (w = 0; w < 4000 && book.owed.size() != 0; w++) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (book.owed.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, book.owed.size());
			book.errors += book.owed.size();
		end

		$display("%0d commands over %0d payload_start settings, %0d results checked",
			items, settings_used, book.checked);
		$display("status mix: ok %0d order %0d offset %0d full %0d missing %0d badlen %0d empty %0d",
			book.stat_tally[nhstl_pkg::STAT_OK], book.stat_tally[nhstl_pkg::STAT_ORDER],
			book.stat_tally[nhstl_pkg::STAT_OFFSET], book.stat_tally[nhstl_pkg::STAT_FULL],
			book.stat_tally[nhstl_pkg::STAT_NOT_FOUND],
			book.stat_tally[nhstl_pkg::STAT_BAD_LEN],
			book.stat_tally[nhstl_pkg::STAT_EMPTY]);
		if (book.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
